@@ hw/rtl/jbce_pkg.sv @@
// Shared types and constants for the JTAG bit to command byte encoder.
package jbce_pkg;

  localparam int SLOTS = 6;
  localparam int SLOT_W = $clog2(SLOTS + 1);

  // Request kinds
  localparam logic [1:0] CMD_CLOCK = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_SLEEP = 2'd2;
  localparam logic [1:0] CMD_RESET = 2'd3;

  // Result actions
  localparam logic [1:0] ACT_EMIT = 2'd0;
  localparam logic [1:0] ACT_PUSH = 2'd1;
  localparam logic [1:0] ACT_WAIT = 2'd2;

  // Repeat count selectors carried by each result slot
  localparam logic [1:0] REP_ONE   = 2'd0;
  localparam logic [1:0] REP_TWO   = 2'd1;
  localparam logic [1:0] REP_DIV   = 2'd2;
  localparam logic [1:0] REP_SLEEP = 2'd3;

  // Adapter command bytes
  localparam logic [7:0] OP_START    = 8'hA4;
  localparam logic [7:0] OP_TDI_ONE  = 8'hCB;
  localparam logic [7:0] OP_TDI_ZERO = 8'hCA;
  localparam logic [7:0] OP_TMS_ONE  = 8'hEC;
  localparam logic [7:0] OP_TMS_ZERO = 8'hE8;
  localparam logic [7:0] OP_RST_ON   = 8'hEA;
  localparam logic [7:0] OP_DELAY    = 8'h80;
  localparam logic [7:0] OP_FLUSH    = 8'hA0;
  localparam logic [7:0] OP_CAPTURE  = 8'h10;
  localparam logic [7:0] OP_TCK_HIGH = 8'h04;
  localparam logic [7:0] OP_RST_BIT  = 8'h02;
  localparam logic [3:0] OP_PACK4    = 4'h3;

  // Sleep: up to LONG_SLEEP_US gives one delay byte per 170 us.
  // q = (us * SLEEP_RECIP) >> SLEEP_SHIFT is exact for us below about 199000.
  localparam logic [31:0] LONG_SLEEP_US = 32'd100000;
  localparam int          SHORT_US_W    = 17;
  localparam logic [16:0] SLEEP_RECIP   = 17'd98690;
  localparam int          SLEEP_SHIFT   = 24;

  localparam logic [2:0] REG_DIVIDER = 3'd0;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] code;
    logic [1:0] rep_sel;
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0]  slots;
    logic [SLOT_W-1:0]  count;
    logic [31:0]        arg;   // host wait, or sleep quotient in the low bits
  } desc_t;

endpackage

@@ hw/rtl/jbce_front.sv @@
// Front end: accepts requests, tracks line state and builds result descriptors.
module jbce_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         command,
  input  logic               tms_level,
  input  logic               tdi_level,
  input  logic               capture_tdo,
  input  logic [31:0]        sleep_us,
  input  logic               test_reset,
  input  logic               system_reset,
  input  logic [9:0]         divider,
  output logic               push,
  output jbce_pkg::desc_t    desc
);
  import jbce_pkg::*;

  logic       clock_high, clock_high_next;
  logic       tms_state, tms_state_next;
  logic       reset_active, reset_active_next;
  logic [3:0] packed_tdi_bits, packed_tdi_bits_next;
  logic [1:0] packed_bit_count, packed_bit_count_next;

  logic [SHORT_US_W+16:0] sleep_prod;
  logic [9:0]             sleep_q;
  logic                   long_sleep;
  logic [7:0]             tdi_code;
  logic [3:0]             bits_merged;
  desc_t                  d;

  function automatic desc_t add_slot(desc_t din, logic [1:0] act, logic [7:0] code,
                                     logic [1:0] rs);
    desc_t dout;
    dout = din;
    dout.slots[din.count[2:0]] = '{action: act, code: code, rep_sel: rs};
    dout.count = din.count + SLOT_W'(1);
    return dout;
  endfunction

  assign sleep_prod = sleep_us[SHORT_US_W-1:0] * SLEEP_RECIP;
  assign sleep_q    = sleep_prod[SLEEP_SHIFT+9:SLEEP_SHIFT];
  assign long_sleep = sleep_us > LONG_SLEEP_US;
  assign tdi_code   = tdi_level ? OP_TDI_ONE : OP_TDI_ZERO;
  assign bits_merged = packed_tdi_bits | (4'(tdi_level) << packed_bit_count);

  always_comb begin
    d = '0;
    d.arg = long_sleep ? sleep_us : {22'd0, sleep_q};
    clock_high_next       = clock_high;
    tms_state_next        = tms_state;
    reset_active_next     = reset_active;
    packed_tdi_bits_next  = packed_tdi_bits;
    packed_bit_count_next = packed_bit_count;

    if (command == CMD_CLOCK && clock_high && divider == 10'd0 && !capture_tdo &&
        tms_level == tms_state) begin
      // Store the bit; the fourth one goes out as a packed byte
      if (packed_bit_count == 2'd3) begin
        d = add_slot(d, ACT_EMIT, {OP_PACK4, bits_merged}, REP_ONE);
        packed_tdi_bits_next  = 4'd0;
        packed_bit_count_next = 2'd0;
      end else begin
        packed_tdi_bits_next  = bits_merged;
        packed_bit_count_next = packed_bit_count + 2'd1;
      end
    end else begin
      if (command == CMD_CLOCK && !clock_high)
        d = add_slot(d, ACT_EMIT, OP_START, REP_ONE);
      // Flush a pending pack, only meaningful with TCK high
      if (packed_bit_count != 2'd0 && clock_high) begin
        d = add_slot(d, ACT_EMIT, {2'b00, packed_bit_count - 2'd1, packed_tdi_bits},
                     REP_ONE);
        packed_tdi_bits_next  = 4'd0;
        packed_bit_count_next = 2'd0;
      end
      if (command == CMD_CLOCK) begin
        d = add_slot(d, ACT_EMIT, tdi_code, REP_ONE);
        if (tms_level != tms_state) begin
          d = add_slot(d, ACT_EMIT, (tms_level ? OP_TMS_ONE : OP_TMS_ZERO) |
                       (reset_active ? OP_RST_BIT : 8'h00), REP_ONE);
          tms_state_next = tms_level;
        end
        if (divider > 10'd1)
          d = add_slot(d, ACT_EMIT, tdi_code, REP_DIV);
        d = add_slot(d, ACT_EMIT, tdi_code | OP_TCK_HIGH |
                     (capture_tdo ? OP_CAPTURE : 8'h00), REP_ONE);
        if (divider > 10'd1)
          d = add_slot(d, ACT_EMIT, tdi_code | OP_TCK_HIGH, REP_DIV);
        clock_high_next = 1'b1;
      end else begin
        // Drop TCK before any other request
        if (clock_high) begin
          d = add_slot(d, ACT_EMIT, OP_TDI_ZERO, REP_ONE);
          clock_high_next = 1'b0;
        end
        case (command)
          CMD_FLUSH: begin
            d = add_slot(d, ACT_EMIT, OP_FLUSH, REP_ONE);
            d = add_slot(d, ACT_PUSH, 8'h00, REP_ONE);
          end
          CMD_SLEEP: begin
            if (long_sleep) begin
              d = add_slot(d, ACT_EMIT, OP_FLUSH, REP_ONE);
              d = add_slot(d, ACT_WAIT, 8'h00, REP_ONE);
            end else begin
              d = add_slot(d, ACT_EMIT, OP_DELAY, REP_SLEEP);
            end
          end
          default: begin
            d = add_slot(d, ACT_EMIT, OP_DELAY, REP_TWO);
            reset_active_next = test_reset | system_reset;
            d = add_slot(d, ACT_EMIT, ((test_reset | system_reset) ? OP_RST_ON : OP_TMS_ZERO)
                         | (tms_state ? OP_TCK_HIGH : 8'h00), REP_ONE);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_high       <= 1'b0;
      tms_state        <= 1'b0;
      reset_active     <= 1'b0;
      packed_tdi_bits  <= 4'd0;
      packed_bit_count <= 2'd0;
    end else if (accept) begin
      clock_high       <= clock_high_next;
      tms_state        <= tms_state_next;
      reset_active     <= reset_active_next;
      packed_tdi_bits  <= packed_tdi_bits_next;
      packed_bit_count <= packed_bit_count_next;
    end
  end

  assign push = accept && (d.count != '0);
  assign desc = d;

endmodule

@@ hw/rtl/jbce_queue.sv @@
// Two-entry descriptor queue between the front and back ends.
module jbce_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  jbce_pkg::desc_t    push_desc,
  input  logic               pop,
  output logic               full,
  output logic               valid,
  output jbce_pkg::desc_t    head
);
  import jbce_pkg::*;

  desc_t      entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign full  = fill == 2'd2;
  assign valid = fill != 2'd0;
  assign head  = entries[rd_ptr];

endmodule

@@ hw/rtl/jbce_back.sv @@
// Back end: walks each descriptor and drives one result item per cycle unless m_tready stalls it.
module jbce_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  jbce_pkg::desc_t    head,
  input  logic [9:0]         divider,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,   // out_byte[7:0], repeat_res[17:8], wait_us[49:18]
  output logic [1:0]         m_tuser,   // action[1:0]
  output logic               m_tlast
);
  import jbce_pkg::*;

  logic [2:0]  idx;
  logic        load;
  logic        is_last;
  slot_t       cur;
  logic [9:0]  rep;
  logic [7:0]  out_byte;
  logic [9:0]  repeat_res;
  logic [31:0] wait_us;
  logic [1:0]  action;

  assign cur     = head.slots[idx];
  assign is_last = SLOT_W'(idx) == head.count - SLOT_W'(1);
  assign load    = q_valid && (!m_tvalid || m_tready);
  assign pop     = load && is_last;

  always_comb begin
    case (cur.rep_sel)
      REP_TWO:   rep = 10'd2;
      REP_DIV:   rep = divider - 10'd1;
      REP_SLEEP: rep = head.arg[9:0] + 10'd2;
      default:   rep = 10'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= is_last ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action     <= cur.action;
      out_byte   <= cur.code;
      repeat_res <= rep;
      wait_us    <= (cur.action == ACT_WAIT) ? head.arg : 32'd0;
      m_tlast    <= is_last;
    end
  end

  assign m_tdata = {6'd0, wait_us, repeat_res, out_byte};
  assign m_tuser = action;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (SLOT_W'(idx) < head.count))
    else $error("slot index past descriptor count");
  a_push_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && action != ACT_EMIT) |-> m_tlast)
    else $error("push result not final for its item");
  a_repeat_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (repeat_res != 10'd0))
    else $error("zero repeat count");
  a_idx_clears: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 3'd0))
    else $error("slot index not cleared after pop");
`endif

endmodule

@@ hw/rtl/jtag_bit_to_command_byte_encoder.sv @@
// Top level of the JTAG bit to adapter command byte encoder.
//
//   port group    dir  handshake          payload
//   s_*           in   s_tvalid/s_tready  request: s_tuser command, s_tdata bit fields
//   m_*           out  m_tvalid/m_tready  result: m_tuser action, m_tdata, m_tlast
//   p*            in   psel/penable       clock_divider register at byte address 0
//
// A request is accepted while the two-entry descriptor queue has room. The back end
// emits one result per cycle unless m_tready stalls it; a request has one result per
// filled slot: 0 or 1 for a packed bit, up to 6 for a clocked bit with a TMS change.
// Reset (rst, synchronous) clears line state, the queue, the output and the divider.
// A stalled m_tready holds the output register; requests keep entering until the
// queue fills.
module jtag_bit_to_command_byte_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // tms_level[0], tdi_level[1], capture_tdo[2],
                                 // sleep_us[34:3], test_reset[35], system_reset[36]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_byte[7:0], repeat_res[17:8], wait_us[49:18]
  output logic [1:0]  m_tuser,   // action[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jbce_pkg::*;

  logic [9:0] clock_divider;
  logic       accept;
  logic       push, pop, q_full, q_valid;
  desc_t      push_desc, head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)
      clock_divider <= 10'd0;
    else if (psel && penable && pwrite && pready && {paddr[2], 2'b00} == REG_DIVIDER)
      clock_divider <= pwdata[9:0];
  end

  assign prdata = ({paddr[2], 2'b00} == REG_DIVIDER) ? {22'd0, clock_divider} : 32'd0;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  jbce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (s_tuser),
    .tms_level    (s_tdata[0]),
    .tdi_level    (s_tdata[1]),
    .capture_tdo  (s_tdata[2]),
    .sleep_us     (s_tdata[34:3]),
    .test_reset   (s_tdata[35]),
    .system_reset (s_tdata[36]),
    .divider      (clock_divider),
    .push         (push),
    .desc         (push_desc)
  );

  jbce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head)
  );

  jbce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .divider  (clock_divider),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
